@@ hw/rtl/sbsh_pkg.sv @@
// Package for the seeded byte stream hash: widths, shift amounts and round functions.
package sbsh_pkg;

  localparam int HashW    = 32;
  localparam int ByteW    = 8;
  localparam int PendW    = 24;
  localparam int CountW   = 2;
  localparam int InDataW  = 40;
  localparam int InUserW  = 2;

  // tuser bit positions on the input side
  localparam int UserFirst = 0;
  localparam int UserEmpty = 1;

  // Shift amounts of the mixing round, tail rule and avalanche
  localparam int ShMixHi   = 11;
  localparam int ShMixLo   = 16;
  localparam int ShMixAdd  = 11;
  localparam int ShT3Xor   = 16;
  localparam int ShT3Sign  = 18;
  localparam int ShT3Add   = 11;
  localparam int ShT2Xor   = 11;
  localparam int ShT2Add   = 17;
  localparam int ShT1Xor   = 10;
  localparam int ShT1Add   = 1;
  localparam int ShAv1     = 3;
  localparam int ShAv2     = 5;
  localparam int ShAv3     = 4;
  localparam int ShAv4     = 17;
  localparam int ShAv5     = 25;
  localparam int ShAv6     = 6;

  localparam logic [CountW-1:0] CntZero  = 2'd0;
  localparam logic [CountW-1:0] CntOne   = 2'd1;
  localparam logic [CountW-1:0] CntTwo   = 2'd2;
  localparam logic [CountW-1:0] CntThree = 2'd3;

  typedef logic [HashW-1:0] hash_t;

  // Sign-extend one byte to hash width
  function automatic hash_t sext8(input logic [ByteW-1:0] b);
    sext8 = {{(HashW-ByteW){b[ByteW-1]}}, b};
  endfunction

  // One four-byte mixing round
  function automatic hash_t mix_round(input hash_t h, input logic [15:0] lo,
                                      input logic [15:0] hi);
    hash_t a;
    hash_t t;
    hash_t m;
    a = h + {16'd0, lo};
    t = ({16'd0, hi} << ShMixHi) ^ a;
    m = (a << ShMixLo) ^ t;
    mix_round = m + (m >> ShMixAdd);
  endfunction

  // Tail rule for one to three leftover bytes
  function automatic hash_t tail_mix(input hash_t h, input logic [PendW-1:0] b,
                                     input logic [CountW-1:0] cnt);
    hash_t a;
    hash_t x;
    a = h;
    x = h;
    unique case (cnt)
      CntThree: begin
        a = h + {16'd0, b[15:0]};
        x = a ^ (a << ShT3Xor);
        x = x ^ (sext8(b[23:16]) << ShT3Sign);
        x = x + (x >> ShT3Add);
      end
      CntTwo: begin
        a = h + {16'd0, b[15:0]};
        x = a ^ (a << ShT2Xor);
        x = x + (x >> ShT2Add);
      end
      CntOne: begin
        a = h + sext8(b[7:0]);
        x = a ^ (a << ShT1Xor);
        x = x + (x >> ShT1Add);
      end
      default: begin
        x = h;
      end
    endcase
    tail_mix = x;
  endfunction

  // Avalanche, first two steps
  function automatic hash_t aval_front(input hash_t h);
    hash_t x;
    x = h ^ (h << ShAv1);
    aval_front = x + (x >> ShAv2);
  endfunction

  // Avalanche, last four steps
  function automatic hash_t aval_back(input hash_t h);
    hash_t x;
    x = h ^ (h << ShAv3);
    x = x + (x >> ShAv4);
    x = x ^ (x << ShAv5);
    aval_back = x + (x >> ShAv6);
  endfunction

endpackage

@@ hw/rtl/seeded_byte_stream_hash32_top.sv @@
// Top level of the seeded byte stream hash: byte gathering, mixing and finishing pipeline.
//
//  channel  dir  tdata                              tlast      tuser
//  s_axis   in   [7:0] data_byte, [39:8] seed       last_byte  [0] first_byte, [1] empty_message
//  m_axis   out  [31:0] hash_value                  -          -
//
// One byte is taken per cycle while the input is not held; the gathering and mixing round close
// within that cycle. After the edge that takes its last byte, a hash passes the input register,
// tail rule, front avalanche, then back avalanche into the output register.
// After a last byte, a byte that neither starts a message nor flags it empty waits until
// the finished hash is back in the running register; a stalled output delays this.
// rst clears the running hash, the gathered bytes and all pipeline valids.
// A stalled output freezes the whole finishing pipeline and holds the input.
module seeded_byte_stream_hash32_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sbsh_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] data_byte, [39:8] seed
  input  logic                           s_axis_tlast,  // last_byte
  input  logic [sbsh_pkg::InUserW-1:0]   s_axis_tuser,  // [0] first_byte, [1] empty_message
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sbsh_pkg::HashW-1:0]     m_axis_tdata   // [31:0] hash_value
);
  import sbsh_pkg::*;

  // Running state
  hash_t               running_hash;
  logic [PendW-1:0]    pending_bytes;
  logic [CountW-1:0]   pending_count;

  // Finishing pipeline
  logic                v1, v2, v3;
  logic                wb1, wb2, wb3;
  hash_t               h1, h2, h3;
  logic [PendW-1:0]    tb1;
  logic [CountW-1:0]   tc1;

  // Input fields
  logic [ByteW-1:0]    in_byte;
  hash_t               in_seed;
  logic                in_first, in_empty, in_last;

  logic                adv, stale, accept, clr, wb_fire;
  hash_t               base_hash, mixed, final_hash;
  logic [PendW-1:0]    base_pend, gath_bytes;
  logic [CountW-1:0]   base_cnt, gath_cnt;

  assign in_byte  = s_axis_tdata[ByteW-1:0];
  assign in_seed  = s_axis_tdata[InDataW-1:ByteW];
  assign in_first = s_axis_tuser[UserFirst];
  assign in_empty = s_axis_tuser[UserEmpty];
  assign in_last  = s_axis_tlast;

  // Handshake: advance when output is free; hold bytes that need a hash still in flight
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign stale         = wb1 || wb2 || wb3;
  assign s_axis_tready = adv && !(stale && !in_first && !in_empty);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign clr           = accept && (in_first || in_empty);

  // Seed and gather
  assign base_hash = in_first ? in_seed : running_hash;
  assign base_pend = in_first ? '0 : pending_bytes;
  assign base_cnt  = in_first ? CntZero : pending_count;

  always_comb begin
    mixed      = base_hash;
    gath_bytes = base_pend;
    gath_cnt   = base_cnt + CntOne;
    unique case (base_cnt)
      CntZero:  gath_bytes = {base_pend[23:8], in_byte};
      CntOne:   gath_bytes = {base_pend[23:16], in_byte, base_pend[7:0]};
      CntTwo:   gath_bytes = {in_byte, base_pend[15:0]};
      CntThree: begin
        mixed      = mix_round(base_hash, base_pend[15:0], {in_byte, base_pend[23:16]});
        gath_bytes = '0;
        gath_cnt   = CntZero;
      end
      default:  gath_bytes = base_pend;
    endcase
  end

  assign final_hash = aval_back(h3);
  assign wb_fire    = adv && v3 && wb3 && !clr;

  // Running state update
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash  <= '0;
      pending_bytes <= '0;
      pending_count <= CntZero;
    end else begin
      priority if (accept && in_empty) begin
        running_hash  <= '0;
        pending_bytes <= '0;
        pending_count <= CntZero;
      end else if (accept && in_last) begin
        pending_bytes <= '0;
        pending_count <= CntZero;
      end else if (accept) begin
        running_hash  <= mixed;
        pending_bytes <= gath_bytes;
        pending_count <= gath_cnt;
      end else if (wb_fire) begin
        running_hash  <= final_hash;
      end
    end
  end

  // Finishing pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      wb1 <= 1'b0; wb2 <= 1'b0; wb3 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1  <= accept && (in_last || in_empty);
      wb1 <= accept && in_last && !in_empty;
      v2  <= v1;
      wb2 <= wb1 && !clr;
      v3  <= v2;
      wb3 <= wb2 && !clr;
      m_axis_tvalid <= v3;
    end
  end

  // Finishing pipeline data: tail, front avalanche, back avalanche
  always_ff @(posedge clk) begin
    if (adv) begin
      h1  <= in_empty ? '0 : mixed;
      tb1 <= in_empty ? '0 : gath_bytes;
      tc1 <= in_empty ? CntZero : gath_cnt;
      h2  <= tail_mix(h1, tb1, tc1);
      h3  <= aval_front(h2);
      m_axis_tdata <= final_hash;
    end
  end

  // Checks
  a_empty_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_empty |=> running_hash == '0 && pending_count == CntZero)
    else $error("empty message did not clear the running state");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> pending_count == CntZero)
    else $error("gathered bytes survived a last byte");

  a_one_writeback: assert property (@(posedge clk) disable iff (rst)
    $countones({wb1, wb2, wb3}) <= 1)
    else $error("more than one hash marked for write-back");

  a_no_stale_continue: assert property (@(posedge clk) disable iff (rst)
    accept && stale |-> in_first || in_empty)
    else $error("byte continued a hash still being finished");

endmodule
